[rtl/efr_pkg.sv]
package efr_pkg;

  localparam int BUFFER_DEPTH_DEF = 64;
  localparam int BYTE_W           = 8;
  localparam int COUNT_W          = 7;
  localparam int CFG_IDX_W        = 2;

  localparam logic [BYTE_W-1:0] START_RST  = 8'd2;
  localparam logic [BYTE_W-1:0] STOP_RST   = 8'd3;
  localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'd27;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START  = 2'd0,
    CFG_STOP   = 2'd1,
    CFG_ESCAPE = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_LEN,
    ST_LEN_ESC,
    ST_DATA,
    ST_DATA_ESC,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic set_len;
    logic store;
    logic clear_frame;
    logic rd_start;
    logic rd_en;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_start;
    logic is_stop;
    logic is_escape;
    logic out_free;
    logic emit_last;
  } status_t;

endpackage

[rtl/efr_ram.sv]
module efr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/efr_ctrl.sv]
module efr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  efr_pkg::status_t stat,
  output efr_pkg::cmd_t    cmd
);

  efr_pkg::state_t state, state_next;
  logic            acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= efr_pkg::ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    acc        = 1'b0;
    unique case (state)
      efr_pkg::ST_HUNT: begin
        s_tready = 1'b1;
        acc      = s_tvalid;
        if (acc && stat.is_start) begin
          state_next = efr_pkg::ST_LEN;
        end
      end
      efr_pkg::ST_LEN: begin
        s_tready = 1'b1;
        acc      = s_tvalid;
        if (acc) begin
          if (stat.is_start || stat.is_stop) begin
            state_next = efr_pkg::ST_LEN;
          end else if (stat.is_escape) begin
            state_next = efr_pkg::ST_LEN_ESC;
          end else begin
            cmd.set_len = 1'b1;
            state_next  = efr_pkg::ST_DATA;
          end
        end
      end
      efr_pkg::ST_LEN_ESC: begin
        s_tready = 1'b1;
        acc      = s_tvalid;
        if (acc) begin
          cmd.set_len = 1'b1;
          state_next  = efr_pkg::ST_DATA;
        end
      end
      efr_pkg::ST_DATA: begin
        s_tready = 1'b1;
        acc      = s_tvalid;
        if (acc) begin
          if (stat.is_start) begin
            cmd.clear_frame = 1'b1;
            state_next      = efr_pkg::ST_LEN;
          end else if (stat.is_stop) begin
            cmd.rd_start = 1'b1;
            state_next   = efr_pkg::ST_EMIT_RD;
          end else if (stat.is_escape) begin
            state_next = efr_pkg::ST_DATA_ESC;
          end else begin
            cmd.store = 1'b1;
          end
        end
      end
      efr_pkg::ST_DATA_ESC: begin
        s_tready = 1'b1;
        acc      = s_tvalid;
        if (acc) begin
          cmd.store  = 1'b1;
          state_next = efr_pkg::ST_DATA;
        end
      end
      efr_pkg::ST_EMIT_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = efr_pkg::ST_EMIT_LD;
      end
      efr_pkg::ST_EMIT_LD: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          if (stat.emit_last) begin
            cmd.clear_frame = 1'b1;
            state_next      = efr_pkg::ST_HUNT;
          end else begin
            state_next = efr_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = efr_pkg::ST_HUNT;
      end
    endcase
  end

endmodule

[rtl/efr_dp.sv]
module efr_dp #(
  parameter int BUFFER_DEPTH = efr_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [efr_pkg::BYTE_W-1:0]    rx_byte,
  input  logic                          cfg_write,
  input  logic [efr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [efr_pkg::BYTE_W-1:0]    cfg_data,
  input  efr_pkg::cmd_t                 cmd,
  output efr_pkg::status_t              stat,
  input  logic                          m_tready,
  output logic                          m_tvalid,
  output logic [23:0]                   m_tdata,
  output logic                          m_tuser,
  output logic                          m_tlast
);

  localparam int AW  = $clog2(BUFFER_DEPTH);
  localparam int CW  = $clog2(BUFFER_DEPTH + 1);
  localparam int RCW = efr_pkg::COUNT_W;
  localparam int BW  = efr_pkg::BYTE_W;

  logic [BW-1:0] start_value, stop_value, escape_value;
  logic [BW-1:0] frame_length;
  logic [CW-1:0] fill_count;
  logic          overflowed;
  logic [AW-1:0] rd_idx;
  logic [BW-1:0] ram_q;
  logic          ram_we;

  logic           out_valid;
  logic [BW-1:0]  out_byte;
  logic [BW-1:0]  out_len;
  logic [RCW-1:0] out_count;
  logic           out_ovf;
  logic           out_has;
  logic           out_last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_value  <= efr_pkg::START_RST;
      stop_value   <= efr_pkg::STOP_RST;
      escape_value <= efr_pkg::ESCAPE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        efr_pkg::CFG_START:  start_value  <= cfg_data;
        efr_pkg::CFG_STOP:   stop_value   <= cfg_data;
        efr_pkg::CFG_ESCAPE: escape_value <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ram_we = cmd.store && (fill_count < CW'(BUFFER_DEPTH));

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= '0;
      fill_count   <= '0;
      overflowed   <= 1'b0;
    end else if (cmd.clear_frame) begin
      frame_length <= '0;
      fill_count   <= '0;
      overflowed   <= 1'b0;
    end else begin
      if (cmd.set_len) begin
        frame_length <= rx_byte;
      end
      if (ram_we) begin
        fill_count <= fill_count + CW'(1);
      end else if (cmd.store) begin
        overflowed <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_start) begin
      rd_idx <= '0;
    end else if (cmd.load_out) begin
      rd_idx <= rd_idx + AW'(1);
    end
  end

  efr_ram #(
    .WIDTH (BW),
    .DEPTH (BUFFER_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_count[AW-1:0]),
    .wdata (rx_byte),
    .re    (cmd.rd_en),
    .raddr (rd_idx),
    .rdata (ram_q)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_has   <= (fill_count != '0);
      out_byte  <= (fill_count != '0) ? ram_q : '0;
      out_last  <= stat.emit_last;
      out_len   <= frame_length;
      out_count <= RCW'(fill_count);
      out_ovf   <= overflowed;
    end
  end

  assign stat.is_start  = (rx_byte == start_value);
  assign stat.is_stop   = (rx_byte == stop_value);
  assign stat.is_escape = (rx_byte == escape_value);
  assign stat.out_free  = !out_valid || m_tready;
  assign stat.emit_last = (fill_count == '0) || (CW'(rd_idx) + CW'(1) == fill_count);

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_ovf, out_count, out_len, out_byte};
  assign m_tuser  = out_has;
  assign m_tlast  = out_last;

endmodule

[rtl/escaped_frame_receiver.sv]
// Ordinary bytes are taken at one per cycle; s_tready stays high outside emission.
// A stop byte starts emission: each result takes one buffer read, then one output register
// load that waits while m_tready stalls a held result; the next byte is read after that load.
// An empty frame gives one marker result. No input is taken while emitting.
// Synchronous reset clears the state machine, frame counters, output valid and sets
// the start/stop/escape registers to 2/3/27; the payload buffer is not cleared.
module escaped_frame_receiver #(
  parameter int BUFFER_DEPTH = efr_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [7:0] payload_byte, [15:8] declared_length, [22:16] received_count, [23] overflow
  output logic [23:0]                   m_tdata,
  output logic                          m_tuser,   // [0] has_data
  output logic                          m_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [efr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);

  efr_pkg::cmd_t    cmd;
  efr_pkg::status_t stat;

  assign cfg_ready = 1'b1;

  efr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  efr_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (s_tdata),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // never overwrite a result that is still waiting
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("result loaded over a stalled transfer");

  // input is closed while the buffer is read out
  a_no_input_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> !s_tready)
    else $error("input open during emission");

  // empty-frame marker is always the end of its run
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tlast && m_tdata[22:16] == 7'd0))
    else $error("marker result without last");

  // a data result reports at least one stored byte
  a_data_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[22:16] != 7'd0))
    else $error("data result with zero count");

endmodule
